### hw/rtl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and codes for the service area list parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

  localparam int ByteW    = 8;
  localparam int TypeW    = 2;
  localparam int CountW   = 5;
  localparam int PlmnW    = 12;
  localparam int TacW     = 24;
  localparam int StatusW  = 2;
  localparam int OutDataW = 56;
  localparam int OutUserW = 3;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_MISMATCH = 2'd1;
  localparam logic [StatusW-1:0] ST_EARLY    = 2'd2;

  localparam logic [TypeW-1:0] TYPE_NONCONSEC = 2'd0;
  localparam logic [TypeW-1:0] TYPE_CONSEC    = 2'd1;
  localparam logic [TypeW-1:0] TYPE_MULTI     = 2'd2;
  localparam logic [TypeW-1:0] TYPE_ALL       = 2'd3;

  typedef struct packed {
    logic [TypeW-1:0]   list_type;
    logic               allowed;
    logic [CountW-1:0]  element_count;
    logic [PlmnW-1:0]   country_code;
    logic [PlmnW-1:0]   network_code;
    logic [TacW-1:0]    area_code;
    logic               code_valid;
    logic               end_of_element;
    logic [StatusW-1:0] status;
  } sal_rec_t;

endpackage

`default_nettype wire

### hw/rtl/sal_core.sv
// ----------------------------------------------------------------------------
// sal_core
// Input register, parser state and the per-byte decode step.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_core
  import sal_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [ByteW-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ByteW-1:0] in_byte,
  input  wire logic             in_last,
  input  wire logic             res_ready,
  output logic                  res_load,
  output sal_rec_t              res_rec
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_HDR  = 3'd2;
  localparam logic [2:0] PH_PLMN = 3'd3;
  localparam logic [2:0] PH_TAC  = 3'd4;

  logic [ByteW-1:0] expected_identifier;

  // input register
  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             hold_last;
  logic             step;

  // parser state
  logic [2:0]        phase, phase_next;
  logic [ByteW-1:0]  bytes_left, bytes_left_next;
  logic [TypeW-1:0]  current_type, current_type_next;
  logic              current_allowed, current_allowed_next;
  logic [CountW-1:0] count_total, count_total_next;
  logic [CountW-1:0] elements_done, elements_done_next;
  logic [PlmnW-1:0]  mcc_reg, mcc_reg_next;
  logic [PlmnW-1:0]  mnc_reg, mnc_reg_next;
  logic [TacW-1:0]   tac_reg, tac_reg_next;
  logic [1:0]        byte_in_element, byte_in_element_next;

  logic              emit, valid, end_flag;
  logic [StatusW-1:0] st;
  logic [2:0]        p;
  logic [CountW-1:0] done_inc;

  assign step     = hold_valid && res_ready;
  assign in_ready = !hold_valid || res_ready;
  assign res_load = step && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_identifier <= '0;
    end else if (cfg_wr_en) begin
      expected_identifier <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
  end

  always_comb begin
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    current_type_next    = current_type;
    current_allowed_next = current_allowed;
    count_total_next     = count_total;
    elements_done_next   = elements_done;
    mcc_reg_next         = mcc_reg;
    mnc_reg_next         = mnc_reg;
    tac_reg_next         = tac_reg;
    byte_in_element_next = byte_in_element;
    emit     = 1'b0;
    valid    = 1'b0;
    end_flag = 1'b0;
    st       = ST_OK;
    done_inc = elements_done + CountW'(1);

    // unused phase codes act as idle
    p = (phase > PH_TAC) ? PH_IDLE : phase;

    if (p == PH_IDLE) begin
      bytes_left_next      = '0;
      current_type_next    = '0;
      current_allowed_next = 1'b0;
      count_total_next     = '0;
      elements_done_next   = '0;
      mcc_reg_next         = '0;
      mnc_reg_next         = '0;
      tac_reg_next         = '0;
      byte_in_element_next = '0;
      if (expected_identifier != '0) begin
        if (hold_byte != expected_identifier) begin
          emit     = 1'b1;
          end_flag = 1'b1;
          st       = ST_MISMATCH;
        end else begin
          phase_next = PH_LEN;
        end
      end else begin
        p = PH_LEN;
      end
    end

    if (p == PH_LEN) begin
      bytes_left_next = hold_byte;
      if (hold_byte == '0) begin
        emit     = 1'b1;
        end_flag = 1'b1;
      end else begin
        phase_next = PH_HDR;
      end
    end else if (p != PH_IDLE) begin
      bytes_left_next = bytes_left - ByteW'(1);
      if (p == PH_HDR) begin
        current_allowed_next = hold_byte[7];
        current_type_next    = hold_byte[6:5];
        count_total_next     = hold_byte[4:0];
        elements_done_next   = '0;
        byte_in_element_next = '0;
        tac_reg_next         = '0;
        if (hold_byte[6:5] == TYPE_MULTI && hold_byte[4:0] == '0) begin
          mcc_reg_next = '0;
          mnc_reg_next = '0;
          emit         = 1'b1;
          phase_next   = PH_HDR;
        end else begin
          phase_next = PH_PLMN;
        end
      end else if (p == PH_PLMN) begin
        if (byte_in_element == 2'd0) begin
          mcc_reg_next         = {4'h0, hold_byte};
          byte_in_element_next = 2'd1;
        end else if (byte_in_element == 2'd1) begin
          mcc_reg_next         = {hold_byte[3:0], mcc_reg[7:0]};
          mnc_reg_next         = {hold_byte[7:4], 8'h00};
          byte_in_element_next = 2'd2;
        end else begin
          mnc_reg_next         = {mnc_reg[11:8], hold_byte};
          byte_in_element_next = 2'd0;
          tac_reg_next         = '0;
          if (current_type == TYPE_ALL ||
              (current_type == TYPE_NONCONSEC && count_total == '0)) begin
            emit       = 1'b1;
            phase_next = PH_HDR;
          end else begin
            phase_next = PH_TAC;
          end
        end
      end else begin
        tac_reg_next = {tac_reg[15:0], hold_byte};
        if (byte_in_element < 2'd2) begin
          byte_in_element_next = byte_in_element + 2'd1;
        end else begin
          byte_in_element_next = 2'd0;
          emit               = 1'b1;
          valid              = 1'b1;
          elements_done_next = done_inc;
          if (current_type == TYPE_CONSEC || done_inc == count_total) begin
            phase_next = PH_HDR;
          end else if (current_type == TYPE_MULTI) begin
            phase_next = PH_PLMN;
          end else begin
            phase_next = PH_TAC;
          end
        end
      end
      // length used up
      if (bytes_left_next == '0) begin
        end_flag = 1'b1;
        if (!emit) begin
          emit = 1'b1;
          st   = ST_EARLY;
        end
      end
    end

    // buffer cut off before the element completed
    if (hold_last && !end_flag) begin
      emit     = 1'b1;
      end_flag = 1'b1;
      st       = ST_EARLY;
    end
    if (end_flag) begin
      phase_next           = PH_IDLE;
      byte_in_element_next = 2'd0;
    end

    res_rec.list_type      = current_type_next;
    res_rec.allowed        = current_allowed_next;
    res_rec.element_count  = count_total_next;
    res_rec.country_code   = mcc_reg_next;
    res_rec.network_code   = mnc_reg_next;
    res_rec.area_code      = valid ? tac_reg_next : '0;
    res_rec.code_valid     = valid;
    res_rec.end_of_element = end_flag;
    res_rec.status         = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bytes_left      <= '0;
      current_type    <= '0;
      current_allowed <= 1'b0;
      count_total     <= '0;
      elements_done   <= '0;
      mcc_reg         <= '0;
      mnc_reg         <= '0;
      tac_reg         <= '0;
      byte_in_element <= '0;
    end else if (step) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      current_type    <= current_type_next;
      current_allowed <= current_allowed_next;
      count_total     <= count_total_next;
      elements_done   <= elements_done_next;
      mcc_reg         <= mcc_reg_next;
      mnc_reg         <= mnc_reg_next;
      tac_reg         <= tac_reg_next;
      byte_in_element <= byte_in_element_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sal_out_reg.sv
// ----------------------------------------------------------------------------
// sal_out_reg
// Result register driving the master stream side.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_out_reg
  import sal_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  sal_rec_t                 rec,
  output logic                     ready,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OutDataW-1:0]      m_tdata,
  output logic                     m_tlast,
  output logic [OutUserW-1:0]      m_tuser
);

  sal_rec_t rec_q;

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_q <= rec;
    end
  end

  assign m_tdata = {rec_q.area_code, rec_q.network_code, rec_q.country_code,
                    rec_q.element_count, rec_q.allowed, rec_q.list_type};
  assign m_tlast = rec_q.end_of_element;
  assign m_tuser = {rec_q.status, rec_q.code_valid};

endmodule

`default_nettype wire

### hw/rtl/service_area_list_parser.sv
// ----------------------------------------------------------------------------
// service_area_list_parser
// Decodes a service area list element, one byte per item, into records.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries element bytes: s_tdata is the byte, s_tlast marks the final
//   byte of the available buffer. m_* carries decoded records, one per area
//   code or per partial list without codes, plus error records and a record
//   for an empty element; m_tlast marks the last record of an element.
//   cfg_wr_en/cfg_wr_data load the expected identifier byte (0 = element
//   has no identifier byte); write it only while the block is idle.
//   A record shows on m_tvalid once its byte has passed the input register,
//   the combinational decode step and the result register. Throughput: one
//   byte per cycle while m_tready does not stall the result register.
//   A stall on m_tready holds the result register; the input register then
//   fills if it is empty, and s_tready drops until the result is taken.
//   Reset (rst, synchronous) empties both registers, returns the parser to
//   the start of an element and clears the identifier to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module service_area_list_parser
  import sal_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [ByteW-1:0]    cfg_wr_data,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [ByteW-1:0]    s_tdata,   // [7:0] data_byte
  input  wire logic                s_tlast,   // last_byte
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // [1:0] list_type, [2] allowed, [7:3] element_count, [19:8] country_code,
  // [31:20] network_code, [55:32] area_code
  output logic [OutDataW-1:0]      m_tdata,
  output logic                     m_tlast,   // end_of_element
  output logic [OutUserW-1:0]      m_tuser    // [0] code_valid, [2:1] status
);

  logic     res_ready;
  logic     res_load;
  sal_rec_t res_rec;

  sal_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .in_last     (s_tlast),
    .res_ready   (res_ready),
    .res_load    (res_load),
    .res_rec     (res_rec)
  );

  sal_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .rec      (res_rec),
    .ready    (res_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

### hw/rtl/sal_checker.sv
// ----------------------------------------------------------------------------
// sal_checker
// Port-level checks on the parser's record stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_checker
  import sal_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [OutDataW-1:0] m_tdata,
  input wire logic                m_tlast,
  input wire logic [OutUserW-1:0] m_tuser
);

  logic [StatusW-1:0] status;
  assign status = m_tuser[2:1];

  // a held record stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("record changed while stalled");

  // any error closes the element
  a_err_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_MISMATCH || status == ST_EARLY) |-> m_tlast)
    else $error("error record without end of element");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> status <= ST_EARLY)
    else $error("undefined status code");

  a_no_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[55:32] == '0)
    else $error("area code set on record without code");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("record pending after reset");

endmodule

bind service_area_list_parser sal_checker u_sal_checker (.*);

`default_nettype wire

### tb/service_area_list_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_area_list_parser_tb
// Streams service area list elements into the parser, byte by byte, and
// checks every decoded record against a cycle-free decoder kept here.
// Directed elements first, then random well-formed, cut-off and noisy
// elements under several identifier settings, with random gaps on both
// sides and one long receiver hold-off.
// ----------------------------------------------------------------------------

module service_area_list_parser_tb;
  import sal_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;

  typedef enum logic [3:0] {
    PS_START,
    PS_LENGTH,
    PS_HEADER,
    PS_NETWORK,
    PS_AREA
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [ByteW-1:0]    cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata = '0;   // [7:0] data_byte
  logic                s_tlast = 1'b0; // last_byte
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // [1:0] list_type, [2] allowed, [7:3] element_count, [19:8] country_code,
  // [31:20] network_code, [55:32] area_code
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;        // end_of_element
  logic [OutUserW-1:0] m_tuser;        // [0] code_valid, [2:1] status

  service_area_list_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

  always #10 clk = ~clk;

  byte_item_t  byte_queue[$];
  sal_rec_t    expected_records[$];
  int          errors = 0;
  int          queued_bytes = 0;
  int unsigned cycle_count = 0;
  int          tx_max_gap = 0;
  int          rx_max_gap = 0;
  int          tx_gap = 0;
  int          rx_wait = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // decoder state
  logic [7:0]        ps_ident = '0;
  parse_phase_t      ps_phase = PS_START;
  logic [7:0]        ps_left = '0;
  logic [TypeW-1:0]  ps_type = '0;
  logic              ps_allowed = 1'b0;
  logic [CountW-1:0] ps_count = '0;
  logic [CountW-1:0] ps_done = '0;
  logic [PlmnW-1:0]  ps_mcc = '0;
  logic [PlmnW-1:0]  ps_mnc = '0;
  logic [TacW-1:0]   ps_tac = '0;
  logic [2:0]        ps_idx = '0;

  task automatic decode_byte(input logic [7:0] b, input logic lst);
    sal_rec_t           rec;
    logic               emit;
    logic               valid;
    logic               fin;
    logic [StatusW-1:0] st;
    parse_phase_t       p;
    emit = 1'b0;
    valid = 1'b0;
    fin = 1'b0;
    st = ST_OK;
    p = ps_phase;
    if (p == PS_START) begin
      ps_left = '0;
      ps_type = '0;
      ps_allowed = 1'b0;
      ps_count = '0;
      ps_done = '0;
      ps_mcc = '0;
      ps_mnc = '0;
      ps_tac = '0;
      ps_idx = '0;
      if (ps_ident != 8'h00) begin
        if (b != ps_ident) begin
          emit = 1'b1;
          fin = 1'b1;
          st = ST_MISMATCH;
        end else begin
          ps_phase = PS_LENGTH;
        end
      end else begin
        p = PS_LENGTH;
      end
    end

    if (p == PS_LENGTH) begin
      ps_left = b;
      if (b == 8'h00) begin
        emit = 1'b1;
        fin = 1'b1;
      end else begin
        ps_phase = PS_HEADER;
      end
    end else if (p != PS_START) begin
      ps_left = ps_left - 8'd1;
      case (p)
        PS_HEADER: begin
          ps_allowed = b[7];
          ps_type = b[6:5];
          ps_count = b[4:0];
          ps_done = '0;
          ps_idx = '0;
          ps_tac = '0;
          if (ps_type == TYPE_MULTI && ps_count == 0) begin
            ps_mcc = '0;
            ps_mnc = '0;
            emit = 1'b1;
            ps_phase = PS_HEADER;
          end else begin
            ps_phase = PS_NETWORK;
          end
        end
        PS_NETWORK: begin
          if (ps_idx == 0) begin
            ps_mcc = {4'h0, b};
            ps_idx = 3'd1;
          end else if (ps_idx == 1) begin
            ps_mcc = {b[3:0], ps_mcc[7:0]};
            ps_mnc = {b[7:4], 8'h00};
            ps_idx = 3'd2;
          end else begin
            ps_mnc = {ps_mnc[11:8], b};
            ps_idx = '0;
            ps_tac = '0;
            // lists with a network but no area codes report the header
            if (ps_type == TYPE_ALL || (ps_type == TYPE_NONCONSEC && ps_count == 0)) begin
              emit = 1'b1;
              ps_phase = PS_HEADER;
            end else begin
              ps_phase = PS_AREA;
            end
          end
        end
        default: begin
          ps_tac = {ps_tac[15:0], b};
          if (ps_idx < 2) begin
            ps_idx = ps_idx + 3'd1;
          end else begin
            ps_idx = '0;
            emit = 1'b1;
            valid = 1'b1;
            ps_done = ps_done + 5'd1;
            // consecutive type reads one code whatever the count says
            if (ps_type == TYPE_CONSEC || ps_done == ps_count) begin
              ps_phase = PS_HEADER;
            end else if (ps_type == TYPE_MULTI) begin
              ps_phase = PS_NETWORK;
            end else begin
              ps_phase = PS_AREA;
            end
          end
        end
      endcase
      if (ps_left == 0) begin
        fin = 1'b1;
        if (!emit) begin
          emit = 1'b1;
          st = ST_EARLY;
        end
      end
    end

    if (lst && !fin) begin
      emit = 1'b1;
      fin = 1'b1;
      st = ST_EARLY;
    end
    if (fin) begin
      ps_phase = PS_START;
      ps_idx = '0;
    end
    if (emit) begin
      rec.list_type = ps_type;
      rec.allowed = ps_allowed;
      rec.element_count = ps_count;
      rec.country_code = ps_mcc;
      rec.network_code = ps_mnc;
      rec.area_code = valid ? ps_tac : '0;
      rec.code_valid = valid;
      rec.end_of_element = fin;
      rec.status = st;
      expected_records.push_back(rec);
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    byte_item_t it;
    it.data = data;
    it.last = last;
    byte_queue.push_back(it);
    queued_bytes++;
  endtask

  // one random element: mostly well formed, some with a short length or a
  // cut-off buffer, plus wrong identifiers, empty elements and noise
  task automatic build_element(input logic [7:0] ident);
    logic [7:0] body[$];
    logic [7:0] elem[$];
    int kind;
    int nl;
    int t;
    int c;
    int k;
    int n;
    int cut;
    int i;
    kind = $urandom_range(0, 99);
    if (ident != 8'h00 && kind < 6) begin
      push_byte(ident ^ 8'(1 << $urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end else if (kind >= 94) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
    end else if (kind >= 89) begin
      if (ident != 8'h00) push_byte(ident, 1'b0);
      push_byte(8'h00, 1'($urandom_range(0, 1)));
    end else begin
      nl = $urandom_range(1, 4);
      for (i = 0; i < nl; i++) begin
        t = $urandom_range(0, 3);
        c = ($urandom_range(0, 24) == 0) ? 31 : $urandom_range(0, 3);
        k = (t == 0) ? 3 * c : (t == 1) ? 3 : (t == 2) ? 6 * c : 0;
        if (t != 2) k = k + 3;
        if (body.size() + 1 + k <= 255) begin
          body.push_back({1'($urandom_range(0, 1)), 2'(t), 5'(c)});
          repeat (k) body.push_back(8'($urandom));
        end
      end
      n = body.size();
      if (kind < 18 && n > 1) n = $urandom_range(1, n - 1);
      if (ident != 8'h00) elem.push_back(ident);
      elem.push_back(8'(n));
      for (i = 0; i < n; i++) elem.push_back(body[i]);
      if (kind >= 18 && kind < 34) begin
        cut = $urandom_range(0, elem.size() - 1);
      end else begin
        cut = elem.size() - 1;
      end
      for (i = 0; i <= cut; i++) begin
        push_byte(elem[i], (i == cut) && (cut != elem.size() - 1 || $urandom_range(0, 1) == 1));
      end
    end
  endtask

  task automatic fill_random(input int count, input logic [7:0] ident);
    int start;
    start = queued_bytes;
    while (queued_bytes - start < count) build_element(ident);
  endtask

  // sampled at the falling edge, away from the driving edge
  task automatic wait_drained();
    @(negedge clk);
    while (byte_queue.size() != 0 || s_tvalid || expected_records.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_identifier(input logic [7:0] value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ps_ident = value;
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    int gap;
    byte_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      gap = tx_gap;
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        gap = $urandom_range(0, tx_max_gap);
      end
      if (!s_tvalid || s_tready) begin
        if (gap == 0 && byte_queue.size() != 0) begin
          it = byte_queue.pop_front();
          s_tdata <= it.data;
          s_tlast <= it.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
          if (gap > 0) gap--;
        end
      end
      tx_gap <= gap;
    end
  end

  // record monitor and ready control
  always @(posedge clk) begin
    int w;
    sal_rec_t got;
    sal_rec_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (m_tvalid && m_tready) begin
        got.list_type = m_tdata[1:0];
        got.allowed = m_tdata[2];
        got.element_count = m_tdata[7:3];
        got.country_code = m_tdata[19:8];
        got.network_code = m_tdata[31:20];
        got.area_code = m_tdata[55:32];
        got.code_valid = m_tuser[0];
        got.status = m_tuser[2:1];
        got.end_of_element = m_tlast;
        if (expected_records.size() == 0) begin
          $display("%0t unexpected record: expected none actual %h", $time, got);
          errors++;
        end else begin
          want = expected_records.pop_front();
          compare_field("list_type", 24'(want.list_type), 24'(got.list_type));
          compare_field("allowed", 24'(want.allowed), 24'(got.allowed));
          compare_field("element_count", 24'(want.element_count), 24'(got.element_count));
          compare_field("country_code", 24'(want.country_code), 24'(got.country_code));
          compare_field("network_code", 24'(want.network_code), 24'(got.network_code));
          compare_field("area_code", want.area_code, got.area_code);
          compare_field("code_valid", 24'(want.code_valid), 24'(got.code_valid));
          compare_field("end_of_element", 24'(want.end_of_element),
                        24'(got.end_of_element));
          compare_field("status", 24'(want.status), 24'(got.status));
        end
        w = $urandom_range(0, rx_max_gap);
      end else if (w > 0) begin
        w--;
      end
      rx_wait <= w;
      m_tready <= (w == 0) && (hold_left == 0);
    end
  end

  // long receiver hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_left <= HoldCycles;
      hold_seen <= hold_reqs;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("service_area_list_parser_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, no identifier byte
    tx_max_gap = 2;
    rx_max_gap = 2;
    load_identifier(8'h00);
    push_byte(8'h00, 1'b0);                               // empty element
    push_byte(8'h04, 1'b0);                               // all areas, max fields
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h07, 1'b0);                               // one non-consecutive code
    push_byte(8'h01, 1'b0); push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hAB, 1'b0);
    // consecutive with count 5, multi-network with count 0, codes-less list
    push_byte(8'h0C, 1'b0);
    push_byte(8'hA5, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h40, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h9A, 1'b0); push_byte(8'hBC, 1'b0); push_byte(8'hDE, 1'b1);
    push_byte(8'h02, 1'b0);                               // length runs out mid-list
    push_byte(8'h60, 1'b0); push_byte(8'h11, 1'b0);
    push_byte(8'h05, 1'b0);                               // buffer cut off
    push_byte(8'h20, 1'b0); push_byte(8'h01, 1'b1);

    // identifier all ones: mismatch, then match with empty body
    load_identifier(8'hFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    tx_max_gap = 8;
    rx_max_gap = 8;
    fill_random(130, 8'hFF);

    // back to back on both sides
    load_identifier(8'h00);
    tx_max_gap = 0;
    rx_max_gap = 0;
    fill_random(150, 8'h00);

    load_identifier(8'($urandom_range(1, 255)));
    tx_max_gap = 8;
    rx_max_gap = 0;
    fill_random(150, ps_ident);

    // receiver stalls while the sender keeps pushing
    load_identifier(8'h00);
    tx_max_gap = 0;
    rx_max_gap = 3;
    hold_reqs++;
    fill_random(60, 8'h00);
    wait_drained();
    rx_max_gap = 8;
    fill_random(150, 8'h00);

    wait_drained();
    repeat (6) @(posedge clk);
    if (errors == 0 && expected_records.size() == 0) begin
      $display("service_area_list_parser_tb: clean");
    end else begin
      $display("service_area_list_parser_tb: errors");
    end
    $finish;
  end

endmodule
